>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/lpds_pkg.sv
package lpds_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int RUN_BITS    = 8;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	localparam int RST_THRESHOLD = 193;
	localparam int RST_MEDIAN    = 1613;
	localparam int RST_BUFFER    = 248;
	localparam int RST_LIMIT     = 10;

	localparam logic [SAMPLE_BITS-1:0] RST_THRESHOLD_V = SAMPLE_BITS'(RST_THRESHOLD);
	localparam logic [SAMPLE_BITS-1:0] RST_WIN_LOW_V   = SAMPLE_BITS'(RST_MEDIAN - RST_BUFFER);
	localparam logic [SAMPLE_BITS-1:0] RST_WIN_HIGH_V  = SAMPLE_BITS'(RST_MEDIAN + RST_BUFFER);
	localparam logic [RUN_BITS-1:0]    RST_LIMIT_V     = RUN_BITS'(RST_LIMIT);

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_SENSE    = 2'd1,
		MODE_LOAD     = 2'd2
	} lpds_mode_t;

	typedef enum logic [2:0] {
		REG_OFFSET    = 3'd0,
		REG_THRESHOLD = 3'd1,
		REG_WIN_LOW   = 3'd2,
		REG_WIN_HIGH  = 3'd3,
		REG_LIMIT     = 3'd4
	} lpds_reg_t;

	typedef struct packed {
		logic                   power_enable;
		logic [SAMPLE_BITS-1:0] current_sample;
		logic [SAMPLE_BITS-1:0] sense_sample;
	} lpds_item_t;

	typedef struct packed {
		logic [1:0] load_mode;
		logic       boost_on;
		logic       load_switch_on;
		logic       sense_switch_on;
		logic       connected;
		logic       mode_changed;
	} lpds_result_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] current_offset;
		logic [SAMPLE_BITS-1:0] current_threshold;
		logic [SAMPLE_BITS-1:0] sense_window_low;
		logic [SAMPLE_BITS-1:0] sense_window_high;
		logic [RUN_BITS-1:0]    debounce_limit;
	} lpds_cfg_t;

endpackage

>>> hw/rtl/lpds_cfg.sv
module lpds_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpds_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lpds_pkg::DATA_BITS-1:0] pwdata,
	output logic [lpds_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output lpds_pkg::lpds_cfg_t            cfg
);
	import lpds_pkg::*;

	lpds_cfg_t  cfg_q;
	lpds_reg_t  reg_idx;
	logic       wr_en;

	assign reg_idx = lpds_reg_t'(paddr[ADDR_BITS-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_offset    <= '0;
			cfg_q.current_threshold <= RST_THRESHOLD_V;
			cfg_q.sense_window_low  <= RST_WIN_LOW_V;
			cfg_q.sense_window_high <= RST_WIN_HIGH_V;
			cfg_q.debounce_limit    <= RST_LIMIT_V;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OFFSET:    cfg_q.current_offset    <= pwdata[SAMPLE_BITS-1:0];
				REG_THRESHOLD: cfg_q.current_threshold <= pwdata[SAMPLE_BITS-1:0];
				REG_WIN_LOW:   cfg_q.sense_window_low  <= pwdata[SAMPLE_BITS-1:0];
				REG_WIN_HIGH:  cfg_q.sense_window_high <= pwdata[SAMPLE_BITS-1:0];
				REG_LIMIT:     cfg_q.debounce_limit    <= pwdata[RUN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OFFSET:    prdata = DATA_BITS'(cfg_q.current_offset);
			REG_THRESHOLD: prdata = DATA_BITS'(cfg_q.current_threshold);
			REG_WIN_LOW:   prdata = DATA_BITS'(cfg_q.sense_window_low);
			REG_WIN_HIGH:  prdata = DATA_BITS'(cfg_q.sense_window_high);
			REG_LIMIT:     prdata = DATA_BITS'(cfg_q.debounce_limit);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/lpds_core.sv
module lpds_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  lpds_pkg::lpds_item_t   item_s1,
	input  lpds_pkg::lpds_cfg_t    cfg,
	output lpds_pkg::lpds_result_t res
);
	import lpds_pkg::*;

	lpds_mode_t             mode_q, mode_d;
	logic                   conn_q, conn_d;
	logic [RUN_BITS-1:0]    low_run_q, low_run_d;
	logic [RUN_BITS-1:0]    win_run_q, win_run_d;
	logic                   boost_q, boost_d;
	logic                   load_sw_q, load_sw_d;
	logic                   sense_sw_q, sense_sw_d;
	logic [SAMPLE_BITS-1:0] net_current;
	logic                   in_window;

	function automatic logic [RUN_BITS-1:0] bump(input logic [RUN_BITS-1:0] run);
		return (run == {RUN_BITS{1'b1}}) ? run : run + RUN_BITS'(1);
	endfunction

	assign net_current = (item_s1.current_sample > cfg.current_offset) ?
		item_s1.current_sample - cfg.current_offset : '0;
	assign in_window = (item_s1.sense_sample > cfg.sense_window_low) &&
		(item_s1.sense_sample < cfg.sense_window_high);

	always_comb begin
		mode_d     = mode_q;
		conn_d     = conn_q;
		low_run_d  = low_run_q;
		win_run_d  = win_run_q;
		boost_d    = boost_q;
		load_sw_d  = load_sw_q;
		sense_sw_d = sense_sw_q;
		if (!item_s1.power_enable) begin
			mode_d  = MODE_DISABLED;
			boost_d = 1'b0;
			if (mode_q != MODE_DISABLED) begin
				load_sw_d  = 1'b0;
				sense_sw_d = 1'b0;
			end
		end else begin
			if (conn_q) begin
				low_run_d = (net_current < cfg.current_threshold) ? bump(low_run_q) : '0;
				if (low_run_d > cfg.debounce_limit) begin
					conn_d    = 1'b0;
					low_run_d = '0;
				end
			end else begin
				win_run_d = in_window ? bump(win_run_q) : '0;
				if (win_run_d > cfg.debounce_limit) begin
					conn_d    = 1'b1;
					win_run_d = '0;
				end
			end
			mode_d = conn_d ? MODE_LOAD : MODE_SENSE;
			if (mode_d != mode_q) begin
				boost_d    = conn_d;
				load_sw_d  = conn_d;
				sense_sw_d = !conn_d;
			end
		end
	end

	always_comb begin
		res.load_mode       = mode_d;
		res.boost_on        = boost_d;
		res.load_switch_on  = load_sw_d;
		res.sense_switch_on = sense_sw_d;
		res.connected       = conn_d;
		res.mode_changed    = (mode_d != mode_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DISABLED;
			conn_q     <= 1'b0;
			low_run_q  <= '0;
			win_run_q  <= '0;
			boost_q    <= 1'b0;
			load_sw_q  <= 1'b0;
			sense_sw_q <= 1'b0;
		end else if (fire) begin
			mode_q     <= mode_d;
			conn_q     <= conn_d;
			low_run_q  <= low_run_d;
			win_run_q  <= win_run_d;
			boost_q    <= boost_d;
			load_sw_q  <= load_sw_d;
			sense_sw_q <= sense_sw_d;
		end
	end

endmodule

>>> hw/rtl/load_detect_power_sequencer.sv
// Load-detect power sequencer.
// The item channel (item_valid, item_stall, item) takes one tick beat per cycle while
// item_stall is low, carrying the output enable and the load current and sense voltage
// samples. The result channel (result_valid, result_stall, result) returns one beat per
// item with the mode, pin levels, connected flag and a mode-change flag, in item order.
// An accepted item lands in an input register; when the result register can take a beat,
// the sequencer state is updated and the result register is loaded from it. One item per
// cycle is sustained while the receiver does not stall, limited only by the single update
// of the sequencer state per cycle.
// While the receiver stalls, the result register holds its beat and the input register
// keeps one more item; item_stall rises once both are full.
// The APB port holds five registers at byte addresses 0 to 16: offset, threshold,
// window low, window high and debounce limit. Write them only while the block is idle.
// Reset clears both registers' valid state, sets the mode to disabled with all pins low,
// clears the connected flag and run counts, and loads the register defaults.
module load_detect_power_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  lpds_pkg::lpds_item_t           item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output lpds_pkg::lpds_result_t         result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpds_pkg::ADDR_BITS-1:0] paddr,
	input  logic [lpds_pkg::DATA_BITS-1:0] pwdata,
	output logic [lpds_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);
	import lpds_pkg::*;

	lpds_cfg_t    cfg;
	lpds_item_t   item_s1;
	logic         valid_s1;
	lpds_result_t res;
	lpds_result_t result_q;
	logic         result_valid_q;
	logic         out_free;
	logic         fire;
	logic         take;

	assign out_free     = !result_valid_q || !result_stall;
	assign fire         = valid_s1 && out_free;
	assign item_stall   = valid_s1 && !out_free;
	assign take         = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	lpds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lpds_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res;
		end
	end

endmodule

>>> hw/rtl/lpds_checker.sv
module lpds_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_stall,
	input lpds_pkg::lpds_result_t result
);
	import lpds_pkg::*;

	`include "assert_macros.svh"

	logic is_load;
	logic is_sense;
	logic is_off;

	assign is_load  = result_valid && (result.load_mode == MODE_LOAD);
	assign is_sense = result_valid && (result.load_mode == MODE_SENSE);
	assign is_off   = result_valid && (result.load_mode == MODE_DISABLED);

	`ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
	`ASSERT_IMPLIES(a_load_pins, is_load, result.boost_on && result.load_switch_on && !result.sense_switch_on && result.connected)
	`ASSERT_IMPLIES(a_sense_pins, is_sense, !result.boost_on && !result.load_switch_on && result.sense_switch_on && !result.connected)
	`ASSERT_IMPLIES(a_off_boost, is_off, !result.boost_on)

endmodule

bind load_detect_power_sequencer lpds_checker u_lpds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
